// ----- design/swz_pkg.sv -----
`timescale 1ns / 1ps

package swz_pkg;

    // Window and channel geometry
    localparam int WINDOW_DEPTH  = 16;
    localparam int CHANNELS      = 5;
    localparam int Q88_CHANNELS  = 2;
    localparam int DATA_W        = 16;
    localparam int ROW_W         = CHANNELS * DATA_W;
    localparam int IDX_W         = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W         = $clog2(WINDOW_DEPTH + 1);
    localparam int CHAN_W        = $clog2(CHANNELS);

    // Arithmetic widths
    localparam int VAL_W   = DATA_W + 1;               // sign-extended sample
    localparam int SUM_W   = VAL_W + CNT_W;            // window sum, signed
    localparam int SQ_W    = 2 * DATA_W + CNT_W;       // sum of squares
    localparam int D_W     = SQ_W + CNT_W;             // n*Q - S*S
    localparam int FRAC_W  = 16;
    localparam int ROOT_W  = (D_W + FRAC_W + 1) / 2;   // root of D << 16
    localparam int X_W     = 2 * ROOT_W;
    localparam int NUM_W   = SUM_W + CNT_W;            // n*v - S, signed
    localparam int DIV_W   = NUM_W + FRAC_W;           // dividend |num| << 16
    localparam int MA_W    = SQ_W + 1;
    localparam int MB_W    = SUM_W;
    localparam int P_W     = MA_W + MB_W;
    localparam int STEP_W  = $clog2(DIV_W);
    localparam int CMP_W   = D_W + 32;
    localparam int Z_W     = 16;
    localparam int TOT_W   = 18;
    localparam int CNTR_W  = 32;

    // Configuration registers
    localparam int THR_W       = 18;
    localparam int FLOOR_W     = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = THR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_FLOOR = 1'd1;
    localparam logic [THR_W-1:0]     THR_RESET   = 18'd2048;
    localparam logic [FLOOR_W-1:0]   FLOOR_RESET = 16'd66;

    typedef struct packed {
        logic signed [15:0] health_value;
        logic signed [15:0] loss_value;
        logic        [15:0] crc_errors;
        logic        [15:0] timeouts;
        logic        [15:0] device_faults;
    } swz_in_t;

    typedef struct packed {
        logic signed [15:0] health_zscore;
        logic signed [15:0] loss_z;
        logic signed [15:0] crc_z;
        logic signed [15:0] timeout_zscore;
        logic signed [15:0] fault_z;
        logic        [17:0] total_score;
        logic               scored;
        logic               anomaly_flag;
        logic        [31:0] anomaly_total;
    } swz_out_t;

endpackage

// ----- design/swz_ram.sv -----
`timescale 1ns / 1ps

module swz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one row, read one row with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sliding_window_zscore_anomaly_unit.sv -----
`timescale 1ns / 1ps
// Sliding-window z-score anomaly unit.
// Input channel (in_valid / in_stall / in_data) takes one telemetry sample of
// five metrics per request; output channel (out_valid / out_stall / out_data)
// returns one result per request: five Q8.8 z-scores, their absolute sum, the
// scored and anomaly flags and the saturating anomaly count.
// Config port (cfg_we / cfg_index / cfg_data) writes score_threshold (index 0)
// or deviation_floor (index 1); write only while idle.
// One request is worked at a time; in_stall is high while it is in progress.
// While the window holds two samples or fewer, a request is not scored. Once
// scoring, each channel streams the window through the shared multiplier;
// when its deviation is below the floor or zero the channel is closed there,
// otherwise it goes on through the 29-step square root and the 43-step
// divider before the next channel starts.
// Reset clears the window fill, write pointer, last scores and counter and
// loads the register defaults; the window RAM needs no clearing.
// A result waiting under out_stall is held in the output register; the next
// request is accepted meanwhile and only waits at the end if it is still held.

module sliding_window_zscore_anomaly_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  swz_pkg::swz_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output swz_pkg::swz_out_t                 out_data,
    input  logic                              cfg_we,
    input  logic [swz_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swz_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import swz_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_ACC    = 12'b0000_0000_0010,
        ST_MUL_NQ = 12'b0000_0000_0100,
        ST_MUL_SS = 12'b0000_0000_1000,
        ST_MUL_FN = 12'b0000_0001_0000,
        ST_MUL_FF = 12'b0000_0010_0000,
        ST_MUL_NV = 12'b0000_0100_0000,
        ST_TEST   = 12'b0000_1000_0000,
        ST_SQRT   = 12'b0001_0000_0000,
        ST_DIV    = 12'b0010_0000_0000,
        ST_WRITE  = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CHAN_W-1:0]         chan_reg, chan_next;
    logic [ROW_W-1:0]          smp_reg, smp_next;
    logic [CNT_W-1:0]          rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]          acc_cnt_reg, acc_cnt_next;
    logic                      v1_reg, v1_next;
    logic                      v2_reg, v2_next;
    logic signed [VAL_W-1:0]   w_reg, w_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic signed [P_W-1:0]     prod_reg;
    logic [D_W-1:0]            d_reg, d_next;
    logic [D_W-1:0]            f_reg, f_next;
    logic                      neg_reg, neg_next;
    logic [NUM_W-1:0]          mag_reg, mag_next;
    logic [X_W-1:0]            x_reg, x_next;
    logic [X_W-1:0]            r_reg, r_next;
    logic [X_W-1:0]            bit_reg, bit_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [DIV_W-1:0]          dd_reg, dd_next;
    logic [ROOT_W:0]           rem_reg, rem_next;
    logic [DIV_W-1:0]          q_reg, q_next;
    logic signed [Z_W-1:0]     zs_reg [CHANNELS];
    logic [TOT_W-1:0]          tot_acc_reg, tot_acc_next;
    logic [TOT_W-1:0]          total_reg, total_next;
    logic                      scored_reg, scored_next;
    logic                      flag_reg, flag_next;
    logic [CNTR_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]          wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [THR_W-1:0]          thr_reg;
    logic [FLOOR_W-1:0]        floor_reg;
    logic                      out_valid_reg, out_valid_next;
    swz_out_t                  out_reg, out_next;

    logic [ROW_W-1:0]          ram_rdata;
    logic                      ram_we;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [P_W-1:0]     mul_p;
    logic signed [VAL_W-1:0]   w_cur;
    logic signed [VAL_W-1:0]   v_cur;
    logic signed [NUM_W-1:0]   num;
    logic [CMP_W-1:0]          d_sh;
    logic [D_W-1:0]            f_sh;
    logic                      below;
    logic [X_W:0]              sq_try;
    logic [ROOT_W:0]           div_try;
    logic [Z_W-1:0]            q_cap;
    logic signed [Z_W-1:0]     z_val;
    logic                      z_we;

    // Pick one channel out of a row, sign-extending the Q8.8 channels
    function automatic logic signed [VAL_W-1:0] chan_val(
        input logic [ROW_W-1:0]  row,
        input logic [CHAN_W-1:0] ch
    );
        logic [DATA_W-1:0] raw;
        raw = row[ch*DATA_W +: DATA_W];
        if (32'(ch) < Q88_CHANNELS)
        begin
            return signed'({raw[DATA_W-1], raw});
        end
        return signed'({1'b0, raw});
    endfunction

    swz_ram #(
        .WIDTH (ROW_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (smp_reg),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign w_cur = chan_val(ram_rdata, chan_reg);
    assign v_cur = chan_val(smp_reg, chan_reg);
    assign ram_we = (state_reg == ST_WRITE);

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ACC:
            begin
                mul_a = MA_W'(w_cur);
                mul_b = MB_W'(w_cur);
            end
            ST_MUL_NQ:
            begin
                mul_a = signed'(MA_W'(sq_reg));
                mul_b = signed'(MB_W'(fill_reg));
            end
            ST_MUL_SS:
            begin
                mul_a = MA_W'(sum_reg);
                mul_b = sum_reg;
            end
            ST_MUL_FN:
            begin
                mul_a = signed'(MA_W'(floor_reg));
                mul_b = signed'(MB_W'(fill_reg));
            end
            ST_MUL_FF:
            begin
                mul_a = signed'(MA_W'(prod_reg[MB_W-1:0]));
                mul_b = signed'(prod_reg[MB_W-1:0]);
            end
            ST_MUL_NV:
            begin
                mul_a = MA_W'(v_cur);
                mul_b = signed'(MB_W'(fill_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Deviation floor test and numerator
    assign num   = signed'(prod_reg[NUM_W-1:0]) - NUM_W'(sum_reg);
    assign d_sh  = (32'(chan_reg) < Q88_CHANNELS) ? (CMP_W'(d_reg) << 16)
                                                    : (CMP_W'(d_reg) << 32);
    assign f_sh  = (32'(chan_reg) < Q88_CHANNELS) ? (f_reg >> 16) : (f_reg >> 32);
    assign below = (d_reg <= f_sh) && (d_sh < CMP_W'(f_reg));

    // Square root and divider step values
    assign sq_try  = {1'b0, r_reg} + {1'b0, bit_reg};
    assign div_try = {rem_reg[ROOT_W-1:0], dd_reg[DIV_W-1]};

    // Saturate the quotient into a Q8.8 z-score
    always_comb
    begin
        if (neg_reg)
        begin
            q_cap = (q_reg > DIV_W'(32768)) ? Z_W'(32768) : q_reg[Z_W-1:0];
        end
        else
        begin
            q_cap = (q_reg > DIV_W'(32767)) ? Z_W'(32767) : q_reg[Z_W-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        chan_next      = chan_reg;
        smp_next       = smp_reg;
        rd_cnt_next    = rd_cnt_reg;
        acc_cnt_next   = acc_cnt_reg;
        v1_next        = 1'b0;
        v2_next        = v1_reg;
        w_next         = w_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        d_next         = d_reg;
        f_next         = f_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        x_next         = x_reg;
        r_next         = r_reg;
        bit_next       = bit_reg;
        step_next      = step_reg;
        dd_next        = dd_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        tot_acc_next   = tot_acc_reg;
        total_next     = total_reg;
        scored_next    = scored_reg;
        flag_next      = flag_reg;
        cnt_next       = cnt_reg;
        wr_idx_next    = wr_idx_reg;
        fill_next      = fill_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        z_val          = '0;
        z_we           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    smp_next     = {in_data.device_faults, in_data.timeouts,
                                    in_data.crc_errors, in_data.loss_value,
                                    in_data.health_value};
                    scored_next  = (fill_reg > CNT_W'(2));
                    flag_next    = 1'b0;
                    chan_next    = '0;
                    tot_acc_next = '0;
                    rd_cnt_next  = '0;
                    acc_cnt_next = '0;
                    sum_next     = '0;
                    sq_next      = '0;
                    state_next   = (fill_reg > CNT_W'(2)) ? ST_ACC : ST_WRITE;
                end
            end
            ST_ACC:
            begin
                // Stream the window through the multiplier
                if (rd_cnt_reg < fill_reg)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    v1_next     = 1'b1;
                end
                if (v1_reg)
                begin
                    w_next = w_cur;
                end
                if (v2_reg)
                begin
                    sum_next     = sum_reg + SUM_W'(w_reg);
                    sq_next      = sq_reg + prod_reg[SQ_W-1:0];
                    acc_cnt_next = acc_cnt_reg + 1'b1;
                end
                if (acc_cnt_reg == fill_reg)
                begin
                    state_next = ST_MUL_NQ;
                end
            end
            ST_MUL_NQ:
            begin
                state_next = ST_MUL_SS;
            end
            ST_MUL_SS:
            begin
                d_next     = prod_reg[D_W-1:0];
                state_next = ST_MUL_FN;
            end
            ST_MUL_FN:
            begin
                d_next     = d_reg - prod_reg[D_W-1:0];
                state_next = ST_MUL_FF;
            end
            ST_MUL_FF:
            begin
                state_next = ST_MUL_NV;
            end
            ST_MUL_NV:
            begin
                f_next     = prod_reg[D_W-1:0];
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                neg_next = num[NUM_W-1];
                mag_next = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                if (below || (d_reg == '0))
                begin
                    z_we = 1'b1;
                end
                else
                begin
                    x_next     = X_W'({d_reg, {FRAC_W{1'b0}}});
                    r_next     = '0;
                    bit_next   = X_W'(1) << (X_W - 2);
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // One root bit per cycle
                if ({1'b0, x_reg} >= sq_try)
                begin
                    x_next = x_reg - sq_try[X_W-1:0];
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    dd_next    = DIV_W'({mag_reg, {FRAC_W{1'b0}}});
                    rem_next   = '0;
                    q_next     = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // One quotient bit per cycle
                if (div_try >= {1'b0, r_reg[ROOT_W-1:0]})
                begin
                    rem_next = div_try - {1'b0, r_reg[ROOT_W-1:0]};
                    q_next   = {q_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_try;
                    q_next   = {q_reg[DIV_W-2:0], 1'b0};
                end
                dd_next   = dd_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WRITE:
            begin
                // Commit the scores when scored and push the sample into the window
                if (scored_reg)
                begin
                    total_next = tot_acc_reg;
                    if (tot_acc_reg > thr_reg)
                    begin
                        flag_next = 1'b1;
                        if (cnt_reg != '1)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
                wr_idx_next = (wr_idx_reg == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                       : wr_idx_reg + 1'b1;
                if (fill_reg < CNT_W'(WINDOW_DEPTH))
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!scored_reg || (chan_reg == CHAN_W'(CHANNELS)))
                begin
                    // Hand the result to the output register
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_next.health_zscore  = zs_reg[0];
                        out_next.loss_z         = zs_reg[1];
                        out_next.crc_z          = zs_reg[2];
                        out_next.timeout_zscore = zs_reg[3];
                        out_next.fault_z        = zs_reg[4];
                        out_next.total_score    = total_reg;
                        out_next.scored         = scored_reg;
                        out_next.anomaly_flag   = flag_reg;
                        out_next.anomaly_total  = cnt_reg;
                        out_valid_next          = 1'b1;
                        state_next              = ST_IDLE;
                    end
                end
                else
                begin
                    // Divider finished for this channel
                    z_val = neg_reg ? Z_W'(-q_cap) : q_cap;
                    z_we  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Close one channel: add |z|, then advance or finish
        if (z_we)
        begin
            tot_acc_next = tot_acc_reg + TOT_W'(z_val == '0 ? Z_W'(0) : q_cap);
            rd_cnt_next  = '0;
            acc_cnt_next = '0;
            sum_next     = '0;
            sq_next      = '0;
            if (chan_reg == CHAN_W'(CHANNELS - 1))
            begin
                chan_next  = CHAN_W'(CHANNELS);
                state_next = ST_WRITE;
            end
            else
            begin
                chan_next  = chan_reg + 1'b1;
                state_next = ST_ACC;
            end
        end
    end

    // Control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            total_reg     <= '0;
            cnt_reg       <= '0;
            wr_idx_reg    <= '0;
            fill_reg      <= '0;
            thr_reg       <= THR_RESET;
            floor_reg     <= FLOOR_RESET;
            out_valid_reg <= 1'b0;
            chan_reg      <= '0;
            scored_reg    <= 1'b0;
            flag_reg      <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                zs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            total_reg     <= total_next;
            cnt_reg       <= cnt_next;
            wr_idx_reg    <= wr_idx_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            chan_reg      <= chan_next;
            scored_reg    <= scored_next;
            flag_reg      <= flag_next;
            if (z_we)
            begin
                zs_reg[chan_reg] <= z_val;
            end
            // Register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCORE_THRESHOLD: thr_reg   <= cfg_data[THR_W-1:0];
                    CFG_DEVIATION_FLOOR: floor_reg <= cfg_data[FLOOR_W-1:0];
                    default:             thr_reg   <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg     <= smp_next;
        rd_cnt_reg  <= rd_cnt_next;
        acc_cnt_reg <= acc_cnt_next;
        w_reg       <= w_next;
        sum_reg     <= sum_next;
        sq_reg      <= sq_next;
        prod_reg    <= mul_p;
        d_reg       <= d_next;
        f_reg       <= f_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        x_reg       <= x_next;
        r_reg       <= r_next;
        bit_reg     <= bit_next;
        step_reg    <= step_next;
        dd_reg      <= dd_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        tot_acc_reg <= tot_acc_next;
        out_reg     <= out_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
